FILE: src/digamma_asymptotic_recurrence_unit_macros.svh
// Assertion macros shared by the digamma unit RTL.
`ifndef DIGAMMA_ASYMPTOTIC_RECURRENCE_UNIT_MACROS_SVH
`define DIGAMMA_ASYMPTOTIC_RECURRENCE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DAR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dar_pkg.sv
// Shared constants and types of the digamma unit.
package dar_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 16;

    localparam logic [15:0] SHIFT_RESET = 16'd253;

    // ln(2) in Q.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    // reciprocal sum cap, 2^30 real in Q.32
    localparam logic [62:0] RSUM_CAP = 63'h4000_0000_0000_0000;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [5:0]  DIV_STEPS = 6'd33;
    localparam logic [33:0] RECIP_REM = 34'h0_8000_0000; // 2^31: numerator 2^64

    // Constant dividers as multiply and shift, exact for numerators up to 2^32:
    // x/12 = (x*RECIP12)>>35, x/120 = (x*RECIP120)>>38, x/252 = (x*RECIP252)>>40
    localparam logic [32:0] RECIP12  = 33'd2863311531;
    localparam logic [32:0] RECIP120 = 33'd2290649225;
    localparam logic [32:0] RECIP252 = 33'd4363141381;

    typedef struct packed {
        logic        start;
        logic [33:0] rem_init;
        logic [32:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [32:0] quo;
    } div_rsp_t;

endpackage

FILE: src/dar_in_if.sv
// Input channel: one argument per transaction.
interface dar_in_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] z_value;

    modport source (output valid, output z_value, input ready);
    modport sink   (input valid, input z_value, output ready);
endinterface

FILE: src/dar_out_if.sv
// Output channel: one digamma result per transaction.
interface dar_out_if #(
    parameter int WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] psi_value;
    logic [1:0]              status;

    modport source (output valid, output psi_value, output status, input ready);
    modport sink   (input valid, input psi_value, input status, output ready);
endinterface

FILE: src/dar_div.sv
// Radix-2 restoring divider, 33 quotient bits, one bit per cycle.
module dar_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dar_pkg::div_req_t req,
    output dar_pkg::div_rsp_t rsp
);

    logic [33:0] rem_reg;
    logic [32:0] quo_reg;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [33:0] rem_shift;
    logic        take;
    logic [33:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg[32:0], quo_reg[32]};
        take      = rem_shift >= {1'b0, den_reg};
        rem_next  = take ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == dar_pkg::DIV_STEPS - 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[31:0], take};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: src/digamma_asymptotic_recurrence_unit.sv
// Top level of the digamma unit: sequencer, shared multiplier and result register.
//
// Computes psi(z) for an unsigned Q(INT).(FRAC) argument and returns a saturated
// signed Q(INT).(FRAC) value with a status code (ok, zero argument, saturated).
// One transaction is worked on at a time; in_ch.ready is high only while the
// sequencer is idle, and a finished result may still wait in the output register
// while the next argument is taken. Arguments above the shift count N use the
// asymptotic series directly. Otherwise the series is taken at z+N and N
// reciprocals 1/(z+i) are subtracted; each reciprocal takes a 7-step normalize
// search, the radix-2 divider and an accumulate step. The reset value of N is
// 253. The log uses 32 squaring rounds on a single registered 33x33 multiplier,
// and the series terms r^2/12, r^4/120, r^6/252 go through the same multiplier
// as multiply-by-reciprocal and shift.
// Internal fixed point is Q.32; the final sum is rounded half up. A zero
// argument returns 0 with the domain status. A shift count of 0 acts as 1.
// shift_count is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module digamma_asymptotic_recurrence_unit #(
    parameter int FRAC_BITS = dar_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = dar_pkg::INT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    dar_in_if.sink      in_ch,
    dar_out_if.source   out_ch
);

`include "digamma_asymptotic_recurrence_unit_macros.svh"

    localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
    localparam int SFT        = 32 - FRAC_BITS;

    localparam logic signed [64:0] HALF =
        (SFT == 0) ? 65'sd0 : (65'sd1 <<< (SFT - 1));
    localparam logic signed [64:0] MAXV = (65'sd1 <<< (TOTAL_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] MINV = -(65'sd1 <<< (TOTAL_BITS - 1));

    localparam logic [TOTAL_BITS-1:0] PSI_MAX = TOTAL_BITS'(MAXV);
    localparam logic [TOTAL_BITS-1:0] PSI_MIN = TOTAL_BITS'(MINV);

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_RDIV, S_RACC,
        S_SQMUL, S_SQADJ, S_LNMUL, S_LNE, S_LNADD,
        S_R2, S_R4, S_R6, S_R6GET, S_T4, S_T6, S_TEND,
        S_ACCR, S_ACCS, S_ROUND, S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]        shift_reg;
    logic [15:0]        n_reg;
    logic [15:0]        i_reg;
    logic [32:0]        wcur_reg;
    logic [32:0]        wi_reg;
    logic [31:0]        zf_reg;
    logic [64:0]        x_reg;
    logic [6:0]         count_reg;
    logic [2:0]         nstep_reg;
    logic               fin_reg;
    logic [62:0]        sum_reg;
    logic [32:0]        y_reg;
    logic [31:0]        frac_reg;
    logic [4:0]         sq_cnt_reg;
    logic [65:0]        prod_reg;
    logic signed [64:0] acc_reg;
    logic [32:0]        r_reg;
    logic [32:0]        r2_reg;
    logic [32:0]        r4_reg;
    logic [32:0]        r6_reg;
    logic               div_start_reg;
    logic [TOTAL_BITS-1:0] res_psi_reg;
    logic [1:0]         res_st_reg;
    logic               out_valid_reg;
    logic [TOTAL_BITS-1:0] out_psi_reg;
    logic [1:0]         out_st_reg;

    dar_pkg::div_req_t div_req;
    dar_pkg::div_rsp_t div_rsp;

    // input decode
    logic [32:0] zi_in;
    logic [31:0] zf_in;
    logic [15:0] n_in;
    logic        direct_in;

    always_comb
    begin
        zi_in     = 33'(in_ch.z_value[TOTAL_BITS-1:FRAC_BITS]);
        zf_in     = 32'(in_ch.z_value[FRAC_BITS-1:0]) << SFT;
        n_in      = (shift_reg == 16'd0) ? 16'd1 : shift_reg;
        direct_in = (zi_in > 33'(n_in)) || ((zi_in == 33'(n_in)) && (zf_in != 32'd0));
    end

    // normalize search: shift by 32,16,8,4,2,1,1 while the top bits are clear
    logic [6:0]  norm_amt;
    logic [64:0] hi_mask;
    logic        top_zero;
    logic [64:0] x_next;

    always_comb
    begin
        case (nstep_reg)
            3'd0:    norm_amt = 7'd32;
            3'd1:    norm_amt = 7'd16;
            3'd2:    norm_amt = 7'd8;
            3'd3:    norm_amt = 7'd4;
            3'd4:    norm_amt = 7'd2;
            default: norm_amt = 7'd1;
        endcase
        hi_mask  = ~({65{1'b1}} >> norm_amt);
        top_zero = (x_reg & hi_mask) == 65'd0;
        x_next   = x_reg << norm_amt;
    end

    // reciprocal scaling by the exponent and sum update
    logic [5:0]  shr;
    logic [5:0]  shl;
    logic [32:0] r_small;
    logic [65:0] r_big;
    logic [62:0] r_loop;
    logic [62:0] room;
    logic        sum_ov;
    logic [5:0]  e_val;

    always_comb
    begin
        shr     = 6'(7'd32 - count_reg);
        shl     = 6'(count_reg - 7'd32);
        e_val   = shr;
        r_small = div_rsp.quo >> shr;
        r_big   = {33'd0, div_rsp.quo} << shl;
        r_loop  = (count_reg <= 7'd32) ? {30'd0, r_small} : r_big[62:0];
        room    = dar_pkg::RSUM_CAP - sum_reg;
        sum_ov  = ((count_reg > 7'd32) && (r_big > {3'd0, dar_pkg::RSUM_CAP}))
                  || (r_loop > room);
    end

    // shared multiplier operand select
    logic [32:0] mul_a;
    logic [32:0] mul_b;

    always_comb
    begin
        case (state_reg)
            S_LNMUL:
            begin
                mul_a = {1'b0, frac_reg};
                mul_b = {1'b0, dar_pkg::LN2_Q32};
            end
            S_LNE:
            begin
                mul_a = {27'd0, e_val};
                mul_b = {1'b0, dar_pkg::LN2_Q32};
            end
            S_R2:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            S_R4:
            begin
                mul_a = prod_reg[64:32];
                mul_b = prod_reg[64:32];
            end
            S_R6:
            begin
                mul_a = prod_reg[64:32];
                mul_b = r2_reg;
            end
            S_R6GET:
            begin
                mul_a = r2_reg;
                mul_b = dar_pkg::RECIP12;
            end
            S_T4:
            begin
                mul_a = r4_reg;
                mul_b = dar_pkg::RECIP120;
            end
            S_T6:
            begin
                mul_a = r6_reg;
                mul_b = dar_pkg::RECIP252;
            end
            default:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
        endcase
    end

    // divider serves the reciprocals 2^64 / m only
    always_comb
    begin
        div_req.start    = div_start_reg;
        div_req.rem_init = dar_pkg::RECIP_REM;
        div_req.num      = 33'd0;
        div_req.den      = x_reg[64:32];
    end

    dar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // rounding of the Q.32 sum
    logic signed [64:0] vh;
    logic signed [64:0] t_rnd;

    always_comb
    begin
        vh    = acc_reg + HALF;
        t_rnd = vh >>> SFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shift_reg     <= dar_pkg::SHIFT_RESET;
            n_reg         <= '0;
            i_reg         <= '0;
            wcur_reg      <= '0;
            wi_reg        <= '0;
            zf_reg        <= '0;
            x_reg         <= '0;
            count_reg     <= '0;
            nstep_reg     <= '0;
            fin_reg       <= 1'b0;
            sum_reg       <= '0;
            y_reg         <= '0;
            frac_reg      <= '0;
            sq_cnt_reg    <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            r_reg         <= '0;
            r2_reg        <= '0;
            r4_reg        <= '0;
            r6_reg        <= '0;
            div_start_reg <= 1'b0;
            res_psi_reg   <= '0;
            res_st_reg    <= dar_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_psi_reg   <= '0;
            out_st_reg    <= dar_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                shift_reg <= cfg_wdata;
            end
            prod_reg      <= mul_a * mul_b;
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        n_reg     <= n_in;
                        i_reg     <= '0;
                        zf_reg    <= zf_in;
                        wcur_reg  <= zi_in;
                        wi_reg    <= zi_in + 33'(n_in);
                        x_reg     <= {zi_in, zf_in};
                        count_reg <= '0;
                        nstep_reg <= '0;
                        sum_reg   <= '0;
                        fin_reg   <= direct_in;
                        if (in_ch.z_value == '0)
                        begin
                            res_psi_reg <= '0;
                            res_st_reg  <= dar_pkg::ST_ZERO;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    if (top_zero)
                    begin
                        x_reg     <= x_next;
                        count_reg <= count_reg + norm_amt;
                    end
                    nstep_reg <= nstep_reg + 3'd1;
                    if (nstep_reg == 3'd6)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_RDIV;
                    end
                end
                S_RDIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (fin_reg)
                        begin
                            r_reg      <= r_small;
                            y_reg      <= x_reg[64:32];
                            frac_reg   <= '0;
                            sq_cnt_reg <= '0;
                            state_reg  <= S_SQMUL;
                        end
                        else
                        begin
                            state_reg <= S_RACC;
                        end
                    end
                end
                S_RACC:
                begin
                    count_reg <= '0;
                    nstep_reg <= '0;
                    if (sum_ov)
                    begin
                        // reciprocal sum ran past its cap
                        res_psi_reg <= PSI_MIN;
                        res_st_reg  <= dar_pkg::ST_SAT;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        sum_reg   <= sum_reg + r_loop;
                        state_reg <= S_NORM;
                        if (i_reg == n_reg - 16'd1)
                        begin
                            x_reg   <= {wi_reg, zf_reg};
                            fin_reg <= 1'b1;
                        end
                        else
                        begin
                            i_reg    <= i_reg + 16'd1;
                            wcur_reg <= wcur_reg + 33'd1;
                            x_reg    <= {wcur_reg + 33'd1, zf_reg};
                        end
                    end
                end
                S_SQMUL:
                begin
                    state_reg <= S_SQADJ;
                end
                S_SQADJ:
                begin
                    if (prod_reg[65])
                    begin
                        y_reg    <= prod_reg[65:33];
                        frac_reg <= {frac_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        y_reg    <= prod_reg[64:32];
                        frac_reg <= {frac_reg[30:0], 1'b0};
                    end
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    state_reg  <= (sq_cnt_reg == 5'd31) ? S_LNMUL : S_SQMUL;
                end
                S_LNMUL:
                begin
                    state_reg <= S_LNE;
                end
                S_LNE:
                begin
                    acc_reg   <= $signed({31'd0, prod_reg[65:32]});
                    state_reg <= S_LNADD;
                end
                S_LNADD:
                begin
                    acc_reg   <= acc_reg + $signed({27'd0, prod_reg[37:0]});
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    state_reg <= S_R4;
                end
                S_R4:
                begin
                    r2_reg    <= prod_reg[64:32];
                    state_reg <= S_R6;
                end
                S_R6:
                begin
                    r4_reg    <= prod_reg[64:32];
                    state_reg <= S_R6GET;
                end
                S_R6GET:
                begin
                    r6_reg    <= prod_reg[64:32];
                    state_reg <= S_T4;
                end
                S_T4:
                begin
                    // r^2/12 subtracts
                    acc_reg   <= acc_reg - $signed({34'd0, prod_reg[65:35]});
                    state_reg <= S_T6;
                end
                S_T6:
                begin
                    // r^4/120 adds
                    acc_reg   <= acc_reg + $signed({37'd0, prod_reg[65:38]});
                    state_reg <= S_TEND;
                end
                S_TEND:
                begin
                    // r^6/252 subtracts
                    acc_reg   <= acc_reg - $signed({39'd0, prod_reg[65:40]});
                    state_reg <= S_ACCR;
                end
                S_ACCR:
                begin
                    acc_reg   <= acc_reg - $signed({33'd0, r_reg[32:1]});
                    state_reg <= S_ACCS;
                end
                S_ACCS:
                begin
                    acc_reg   <= acc_reg - $signed({2'd0, sum_reg});
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (t_rnd < MINV)
                    begin
                        res_psi_reg <= PSI_MIN;
                        res_st_reg  <= dar_pkg::ST_SAT;
                    end
                    else if (t_rnd > MAXV)
                    begin
                        res_psi_reg <= PSI_MAX;
                        res_st_reg  <= dar_pkg::ST_SAT;
                    end
                    else
                    begin
                        res_psi_reg <= t_rnd[TOTAL_BITS-1:0];
                        res_st_reg  <= dar_pkg::ST_OK;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_psi_reg   <= res_psi_reg;
                        out_st_reg    <= res_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.psi_value = out_psi_reg;
    assign out_ch.status    = out_st_reg;

    `DAR_ASSERT_IMPL(a_div_start_idle, div_start_reg, !div_rsp.busy, "divider started while busy")
    `DAR_ASSERT_IMPL(a_sum_cap, 1'b1, sum_reg <= dar_pkg::RSUM_CAP, "reciprocal sum above cap")
    `DAR_ASSERT_NEXT(a_zero_arg, in_ch.valid && in_ch.ready && (in_ch.z_value == '0), (state_reg == S_DONE) && (res_st_reg == dar_pkg::ST_ZERO), "zero argument not flagged")
    `DAR_ASSERT_IMPL(a_sat_end, out_valid_reg && (out_st_reg == dar_pkg::ST_SAT), (out_psi_reg == PSI_MIN) || (out_psi_reg == PSI_MAX), "saturated result not at a range end")

endmodule

FILE: dv/dar_result_checker.sv
// Watches the digamma unit channels, predicts each result and compares it.
module dar_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    dar_in_if           in_ch,
    dar_out_if          out_ch,
    output int          fails,
    output int          pending
);
    import dar_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int TB = FRAC_BITS_DEF + INT_BITS_DEF;
    localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic [31:0] psi;
        logic [1:0]  st;
    } psi_res_t;

    psi_res_t   psi_q[$];
    logic [15:0] shift_n;

    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[95:32];
    endfunction

    function automatic int msb_pos(input logic [63:0] v);
        int p;
        p = 0;
        for (int k = 63; k >= 0; k--)
            if (v[k] && p == 0) p = k;
        return p;
    endfunction

    // mantissa in [2^32, 2^33) and binary exponent of hi + lo/2^32
    function automatic logic [63:0] mant(input logic [63:0] hi, input logic [63:0] lo,
                                         output int ex);
        int p;
        if (hi != 0) begin
            p  = msb_pos(hi);
            ex = p;
            return (hi << (32 - p)) + (lo >> p);
        end
        p  = msb_pos(lo);
        ex = p - 32;
        return lo << (32 - p);
    endfunction

    function automatic logic [63:0] recip_q32(input logic [63:0] hi, input logic [63:0] lo,
                                              inout bit ov);
        int          ex;
        int          s;
        logic [63:0] m;
        logic [64:0] q;
        logic [63:0] rm;
        m  = mant(hi, lo, ex);
        q  = (65'h1 << 64) / {1'b0, m};
        rm = q[63:0];
        if (ex >= 0) return rm >> ex;
        s = -ex;
        if (rm > (CAP >> s)) begin
            ov = 1'b1;
            return CAP;
        end
        return rm << s;
    endfunction

    function automatic logic [63:0] ln_q32(input logic [63:0] hi, input logic [63:0] lo);
        int          ex;
        logic [63:0] y;
        logic [63:0] fr;
        y  = mant(hi, lo, ex);
        fr = 0;
        for (int k = 0; k < 32; k++) begin
            y  = mul_q32(y, y);
            fr = fr << 1;
            if (y >= (64'h1 << 33)) begin
                y     = y >> 1;
                fr[0] = 1'b1;
            end
        end
        return mul_q32({ex[31:0], fr[31:0]}, {32'h0, LN2_Q32});
    endfunction

    function automatic psi_res_t digamma_of(input logic [31:0] z, input logic [15:0] nreg);
        psi_res_t       res;
        logic [63:0]    n, zi, zf, wi, rsum, r, r2, r4, r6, lnw, u, t;
        logic [63:0]    bias, lo_lim, hi_lim;
        longint signed  v;
        bit             ov;
        ov   = 1'b0;
        rsum = 0;
        if (z == 0) return '{psi: '0, st: ST_ZERO};
        n  = (nreg == 0) ? 64'd1 : {48'h0, nreg};
        zi = z >> FB;
        zf = {48'h0, z[FB-1:0]} << (32 - FB);
        if (zi > n || (zi == n && zf != 0)) begin
            wi = zi;
        end else begin
            // upward recurrence: subtract 1/(z+i)
            wi = zi + n;
            for (longint i = 0; i < n; i++) begin
                r = recip_q32(zi + i, zf, ov);
                if (r > CAP - rsum) begin
                    rsum = CAP;
                    ov   = 1'b1;
                end else begin
                    rsum = rsum + r;
                end
            end
        end
        if (ov) return '{psi: 32'h8000_0000, st: ST_SAT};
        lnw = ln_q32(wi, zf);
        r   = recip_q32(wi, zf, ov);
        r2  = mul_q32(r, r);
        r4  = mul_q32(r2, r2);
        r6  = mul_q32(r4, r2);
        v = longint'(lnw) - longint'(r >> 1) - longint'(r2 / 12) + longint'(r4 / 120)
            - longint'(r6 / 252) - longint'(rsum);
        bias   = 64'h1 << (63 - (32 - FB));
        u      = 64'(v) + (64'h1 << 63);
        t      = (u + (64'h1 << (32 - FB - 1))) >> (32 - FB);
        lo_lim = bias - (64'h1 << (TB - 1));
        hi_lim = bias + (64'h1 << (TB - 1)) - 1;
        if (t < lo_lim) begin
            res = '{psi: 32'h8000_0000, st: ST_SAT};
        end else if (t > hi_lim) begin
            res = '{psi: 32'h7FFF_FFFF, st: ST_SAT};
        end else begin
            u   = t - bias;
            res = '{psi: u[31:0], st: ST_OK};
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        psi_res_t want;
        if (!rst_n) begin
            shift_n = SHIFT_RESET;
            fails   = 0;
            pending = 0;
            psi_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (psi_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result psi=%h status=%0d",
                                 out_ch.psi_value, out_ch.status);
                end else begin
                    want = psi_q.pop_front();
                    if (out_ch.psi_value !== want.psi) begin
                        fails++;
                        if (fails <= 10)
                            $display("psi mismatch: expected %h actual %h",
                                     want.psi, out_ch.psi_value);
                    end
                    if (out_ch.status !== want.st) begin
                        fails++;
                        if (fails <= 10)
                            $display("status mismatch: expected %0d actual %0d",
                                     want.st, out_ch.status);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                psi_q.push_back(digamma_of(in_ch.z_value, shift_n));
            if (cfg_we)
                shift_n = cfg_wdata;
            pending = psi_q.size();
        end
    end
endmodule

FILE: dv/tb_digamma_asymptotic_recurrence_unit.sv
// Stimulus and verdict for the digamma unit testbench.
module tb_digamma_asymptotic_recurrence_unit;
    import dar_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fails;
    int          pending;
    int          cycles;
    bit          calm;      // no idling on either side
    bit          hold_go;   // asks the receiver for a long hold-off
    int          hold_left;

    dar_in_if  #(.WIDTH(32)) in_ch ();
    dar_out_if #(.WIDTH(32)) out_ch ();

    digamma_asymptotic_recurrence_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    dar_result_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 80);
    endfunction

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(posedge clk)
    begin
        if (hold_go && hold_left == 0) begin
            hold_left     <= 4000;
            out_ch.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            out_ch.ready  <= (hold_left == 1);
        end else if (calm) begin
            out_ch.ready  <= 1'b1;
        end else if (!out_ch.ready) begin
            out_ch.ready  <= ($urandom_range(0, 9) < 4);
        end else begin
            out_ch.ready  <= ($urandom_range(0, 9) < 8);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One transaction on the input channel; valid stays high between
    // back-to-back items.
    task automatic send_z(input logic [31:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.z_value <= z;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Drain every expected result, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_shift(input logic [15:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random argument: mostly near the recurrence range, some full range.
    function automatic logic [31:0] rand_z(input int n);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 32'h0;
        if (sel < 12) return {16'($urandom_range(0, n + 1)), 16'($urandom)};
        return $urandom;
    endfunction

    initial
    begin
        int n;
        rst_n         = 1'b0;
        calm          = 1'b0;
        hold_go       = 1'b0;
        hold_left     = 0;
        cycles        = 0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.z_value = '0;
        out_ch.ready  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset shift count: zero argument, tiny argument, recurrence edge cases.
        send_z(32'h0000_0000);
        send_z(32'h0000_0001);
        send_z(32'h0001_0000);
        send_z({16'd253, 16'h0000});
        send_z({16'd253, 16'h0001});
        send_z(32'h8000_0000);
        send_z(32'hFFFF_FFFF);

        // Shift count zero acts as one.
        write_shift(16'd0);
        send_z(32'h0000_8000);
        send_z(32'h0001_0000);
        send_z(32'h0001_8000);
        send_z(32'h0000_0001);

        // Largest shift count: only arguments at the top take the direct path.
        write_shift(16'hFFFF);
        send_z(32'hFFFF_0001);
        send_z(32'hFFFF_FFFF);
        send_z(32'h0000_0000);

        write_shift(16'd1);
        send_z(32'h0000_FFFF);
        send_z(32'h7FFF_FFFF);
        send_z(32'h5555_AAAA);

        // Random phases with small shift counts.
        for (int ph = 0; ph < 4; ph++) begin
            n = (ph == 3) ? 1 : $urandom_range(1, 16);
            write_shift(16'(n));
            calm = (ph == 1);
            if (ph == 2) begin
                // long receiver hold-off while fast items keep coming
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
                for (int k = 0; k < 5; k++)
                    send_z({16'($urandom_range(n + 1, 65535)), 16'($urandom)});
            end
            for (int k = 0; k < 25; k++)
                send_z(rand_z(n));
        end
        calm = 1'b0;
        drain();
        repeat (50) @(posedge clk);

        if (fails == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/dar_pkg.sv
src/dar_in_if.sv
src/dar_out_if.sv
src/dar_div.sv
src/digamma_asymptotic_recurrence_unit.sv
dv/dar_result_checker.sv
dv/tb_digamma_asymptotic_recurrence_unit.sv
